/* rtl/rfidcfb_pkg.sv */
// shared types, constants and the control program of the rfid command frame builder
package rfidcfb_pkg;

  localparam int BLOCK_BYTES_DEF = 8;
  localparam int STEP_W          = 5;
  localparam int REPLY_W         = 11;
  localparam int CFG_ADDR_W      = 3;

  localparam logic [7:0] HDR_BYTE   = 8'h40;
  localparam logic [7:0] TAG_MARK   = 8'h22;
  localparam logic [7:0] LEN_SINGLE = 8'h0B;
  localparam logic [7:0] LEN_MULTI  = 8'h0C;
  localparam logic [7:0] LEN_WRITE  = 8'h13;
  localparam logic [7:0] LEN_HIGH   = 8'h00;

  localparam logic [REPLY_W-1:0] WRITE_REPLY = 11'd5;
  localparam logic [REPLY_W-1:0] REPLY_MAX   = 11'd2047;
  localparam int                 REPLY_BASE  = 5;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TAG_UID = 3'd0;

  typedef enum logic [2:0] {
    KIND_READ_SINGLE      = 3'd0,
    KIND_READ_MULTI       = 3'd1,
    KIND_FAST_READ_SINGLE = 3'd2,
    KIND_FAST_READ_MULTI  = 3'd3,
    KIND_READ_MULTI_UNLIM = 3'd4,
    KIND_FAST_MULTI_UNLIM = 3'd5,
    KIND_WRITE            = 3'd6,
    KIND_FAST_WRITE       = 3'd7
  } kind_t;

  // byte source selected by one control word
  typedef enum logic [3:0] {
    SRC_HDR,
    SRC_LEN_LO,
    SRC_LEN_HI,
    SRC_CMD,
    SRC_MARK,
    SRC_UID,
    SRC_START,
    SRC_CNTM1,
    SRC_DLOW,
    SRC_DHIGH,
    SRC_CHECK
  } src_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_IF_WRITE,
    JMP_IF_SINGLE
  } jmp_t;

  typedef struct packed {
    src_t              src;
    logic [2:0]        sel;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              chk_en;
    logic              last;
  } uword_t;

  localparam logic [STEP_W-1:0] STEP_ZERO  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DATA  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_CHECK = 5'd24;

  function automatic uword_t uw(input src_t s, input logic [2:0] sel, input jmp_t j,
                                input logic [STEP_W-1:0] t, input logic c, input logic l);
    uword_t w;
    w.src    = s;
    w.sel    = sel;
    w.jmp    = j;
    w.target = t;
    w.chk_en = c;
    w.last   = l;
    return w;
  endfunction

  // control program, one frame byte per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      5'd0:    w = uw(SRC_HDR,    3'd0, JMP_NONE,      STEP_ZERO,  1'b0, 1'b0);
      5'd1:    w = uw(SRC_LEN_LO, 3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd2:    w = uw(SRC_LEN_HI, 3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd3:    w = uw(SRC_CMD,    3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd4:    w = uw(SRC_MARK,   3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd5:    w = uw(SRC_UID,    3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd6:    w = uw(SRC_UID,    3'd1, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd7:    w = uw(SRC_UID,    3'd2, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd8:    w = uw(SRC_UID,    3'd3, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd9:    w = uw(SRC_UID,    3'd4, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd10:   w = uw(SRC_UID,    3'd5, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd11:   w = uw(SRC_UID,    3'd6, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd12:   w = uw(SRC_UID,    3'd7, JMP_IF_WRITE,  STEP_DATA,  1'b1, 1'b0);
      5'd13:   w = uw(SRC_START,  3'd0, JMP_IF_SINGLE, STEP_CHECK, 1'b1, 1'b0);
      5'd14:   w = uw(SRC_CNTM1,  3'd0, JMP_ALWAYS,    STEP_CHECK, 1'b1, 1'b0);
      5'd15:   w = uw(SRC_DLOW,   3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd16:   w = uw(SRC_DLOW,   3'd1, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd17:   w = uw(SRC_DLOW,   3'd2, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd18:   w = uw(SRC_DLOW,   3'd3, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd19:   w = uw(SRC_DLOW,   3'd4, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd20:   w = uw(SRC_DLOW,   3'd5, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd21:   w = uw(SRC_DLOW,   3'd6, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd22:   w = uw(SRC_DLOW,   3'd7, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      5'd23:   w = uw(SRC_DHIGH,  3'd0, JMP_NONE,      STEP_ZERO,  1'b1, 1'b0);
      default: w = uw(SRC_CHECK,  3'd0, JMP_NONE,      STEP_ZERO,  1'b0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] cmd_code(input kind_t k);
    logic [7:0] c;
    unique case (k)
      KIND_READ_SINGLE:      c = 8'h30;
      KIND_READ_MULTI:       c = 8'h33;
      KIND_FAST_READ_SINGLE: c = 8'hD0;
      KIND_FAST_READ_MULTI:  c = 8'hD3;
      KIND_READ_MULTI_UNLIM: c = 8'hB5;
      KIND_FAST_MULTI_UNLIM: c = 8'hD5;
      KIND_WRITE:            c = 8'h31;
      default:               c = 8'hD1;
    endcase
    return c;
  endfunction

endpackage

/* rtl/rfidcfb_if.sv */
// valid/ready channel interfaces for requests and frame bytes
interface rfidcfb_req_if;
  logic                      valid;
  logic                      ready;
  rfidcfb_pkg::kind_t        kind;
  logic [7:0]                first_block;
  logic [7:0]                block_count;
  logic [63:0]               write_data_low;
  logic [7:0]                write_data_high;

  modport source (output valid, kind, first_block, block_count, write_data_low,
                  write_data_high, input ready);
  modport sink   (input valid, kind, first_block, block_count, write_data_low,
                  write_data_high, output ready);
endinterface

interface rfidcfb_byte_if;
  logic                               valid;
  logic                               ready;
  logic [7:0]                         frame_byte;
  logic                               last_byte;
  logic [rfidcfb_pkg::REPLY_W-1:0]    reply_length;

  modport source (output valid, frame_byte, last_byte, reply_length, input ready);
  modport sink   (input valid, frame_byte, last_byte, reply_length, output ready);
endinterface

/* rtl/rfid_command_frame_builder.sv */
// rfid command frame builder: request in, command frame out one byte per item
//
//  channel   | dir | handshake       | carries
//  ----------+-----+-----------------+---------------------------------------------
//  in_req    | in  | valid / ready   | kind, first_block, block_count, write data
//  out_byte  | out | valid / ready   | frame_byte, last_byte, reply_length
//  cfg_*     | in  | apb, 64-bit     | tag_uid at byte address 0
//
// a request is taken only while no frame is being sequenced; the next one is
// taken while the check byte still sits in the output register.
// frames are 15, 16 or 23 bytes; the control program steps once per byte.
// a stalled output register holds the step counter. rst_n is synchronous and
// clears the sequencer, the output valid and tag_uid.
module rfid_command_frame_builder #(
  parameter int BLOCK_BYTES = rfidcfb_pkg::BLOCK_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rfidcfb_req_if.sink                         in_req,
  rfidcfb_byte_if.source                      out_byte,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rfidcfb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [63:0]                         cfg_pwdata,
  output logic [63:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int PROD_W = 9 + $clog2(BLOCK_BYTES + 1);

  logic [63:0]                         uid_r;
  logic                                busy_r, busy_nxt;
  logic [rfidcfb_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [7:0]                          chk_r, chk_nxt;
  rfidcfb_pkg::kind_t                  kind_r;
  logic [7:0]                          start_r, count_r, dhigh_r;
  logic [63:0]                         dlow_r, huid_r;
  logic [rfidcfb_pkg::REPLY_W-1:0]     reply_r, reply_nxt;
  logic                                ov_r, ov_nxt;
  logic [7:0]                          ob_r, ob_nxt;
  logic                                ol_r, ol_nxt;
  logic [rfidcfb_pkg::REPLY_W-1:0]     orl_r, orl_nxt;

  rfidcfb_pkg::uword_t                 uw;
  logic                                accept, emit;
  logic                                is_write, is_single, in_write, in_single;
  logic [7:0]                          byte_val, len_lo;
  logic [PROD_W-1:0]                   prod;
  logic                                taken;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = uid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == rfidcfb_pkg::ADDR_TAG_UID) begin
      uid_r <= cfg_pwdata;
    end
  end

  assign in_req.ready = !busy_r;
  assign accept       = in_req.valid && !busy_r;

  // reply length of the incoming request
  assign in_write  = in_req.kind == rfidcfb_pkg::KIND_WRITE ||
                     in_req.kind == rfidcfb_pkg::KIND_FAST_WRITE;
  assign in_single = in_req.kind == rfidcfb_pkg::KIND_READ_SINGLE ||
                     in_req.kind == rfidcfb_pkg::KIND_FAST_READ_SINGLE;
  assign prod = PROD_W'(in_req.block_count) * PROD_W'(BLOCK_BYTES) +
                PROD_W'(rfidcfb_pkg::REPLY_BASE);

  always_comb begin
    if (in_write) begin
      reply_nxt = rfidcfb_pkg::WRITE_REPLY;
    end else if (in_single) begin
      reply_nxt = rfidcfb_pkg::REPLY_W'(BLOCK_BYTES + rfidcfb_pkg::REPLY_BASE);
    end else if (prod > PROD_W'(rfidcfb_pkg::REPLY_MAX)) begin
      reply_nxt = rfidcfb_pkg::REPLY_MAX;
    end else begin
      reply_nxt = rfidcfb_pkg::REPLY_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_req.kind;
      start_r <= in_req.first_block;
      count_r <= in_req.block_count;
      dlow_r  <= in_req.write_data_low;
      dhigh_r <= in_req.write_data_high;
      huid_r  <= uid_r;
      reply_r <= reply_nxt;
    end
  end

  // datapath driven by the current control word
  assign uw        = rfidcfb_pkg::ucode(step_r);
  assign is_write  = kind_r == rfidcfb_pkg::KIND_WRITE ||
                     kind_r == rfidcfb_pkg::KIND_FAST_WRITE;
  assign is_single = kind_r == rfidcfb_pkg::KIND_READ_SINGLE ||
                     kind_r == rfidcfb_pkg::KIND_FAST_READ_SINGLE;
  assign len_lo    = is_write  ? rfidcfb_pkg::LEN_WRITE :
                     is_single ? rfidcfb_pkg::LEN_SINGLE : rfidcfb_pkg::LEN_MULTI;

  always_comb begin
    case (uw.src)
      rfidcfb_pkg::SRC_HDR:    byte_val = rfidcfb_pkg::HDR_BYTE;
      rfidcfb_pkg::SRC_LEN_LO: byte_val = len_lo;
      rfidcfb_pkg::SRC_LEN_HI: byte_val = rfidcfb_pkg::LEN_HIGH;
      rfidcfb_pkg::SRC_CMD:    byte_val = rfidcfb_pkg::cmd_code(kind_r);
      rfidcfb_pkg::SRC_MARK:   byte_val = rfidcfb_pkg::TAG_MARK;
      rfidcfb_pkg::SRC_UID:    byte_val = huid_r[{uw.sel, 3'b000} +: 8];
      rfidcfb_pkg::SRC_START:  byte_val = start_r;
      rfidcfb_pkg::SRC_CNTM1:  byte_val = count_r - 8'd1;
      rfidcfb_pkg::SRC_DLOW:   byte_val = dlow_r[{uw.sel, 3'b000} +: 8];
      rfidcfb_pkg::SRC_DHIGH:  byte_val = dhigh_r;
      default:                 byte_val = chk_r;
    endcase
  end

  assign taken = ov_r && out_byte.ready;
  assign emit  = busy_r && (!ov_r || out_byte.ready);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    chk_nxt  = chk_r;
    ov_nxt   = ov_r && !taken;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    orl_nxt  = orl_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = rfidcfb_pkg::STEP_ZERO;
      chk_nxt  = '0;
    end else if (emit) begin
      ov_nxt  = 1'b1;
      ob_nxt  = byte_val;
      ol_nxt  = uw.last;
      orl_nxt = reply_r;
      if (uw.chk_en) begin
        chk_nxt = chk_r ^ byte_val;
      end
      if (uw.last) begin
        busy_nxt = 1'b0;
      end
      case (uw.jmp)
        rfidcfb_pkg::JMP_ALWAYS:    step_nxt = uw.target;
        rfidcfb_pkg::JMP_IF_WRITE:  step_nxt = is_write ? uw.target : step_r + 5'd1;
        rfidcfb_pkg::JMP_IF_SINGLE: step_nxt = is_single ? uw.target : step_r + 5'd1;
        default:                    step_nxt = step_r + 5'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      chk_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      chk_r  <= chk_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    orl_r <= orl_nxt;
  end

  assign out_byte.valid        = ov_r;
  assign out_byte.frame_byte   = ob_r;
  assign out_byte.last_byte    = ol_r;
  assign out_byte.reply_length = orl_r;

endmodule

/* dv/testbench.sv */
// self-checking testbench for rfid_command_frame_builder: predicted frames vs. dut output
module testbench;
  import rfidcfb_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  first_block;
    logic [7:0]  block_count;
    logic [63:0] wdata_lo;
    logic [7:0]  wdata_hi;
  } cmd_req_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic [REPLY_W-1:0] reply;
  } frame_byte_t;

  // directed rows; typed rows carry the check byte and reply length by hand
  typedef struct packed {
    cmd_req_t           req;
    logic               typed;
    logic [7:0]         chk;
    logic [REPLY_W-1:0] reply;
  } dir_row_t;

  typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_DRAIN} press_t;
  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  rfidcfb_req_if  req_ch ();
  rfidcfb_byte_if byte_ch ();

  frame_byte_t pending_bytes [$];
  logic [63:0] uid_now;
  int          errors;
  int          burst_left;
  bit          hold_rx;

  rfid_command_frame_builder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_byte    (byte_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // builds the whole frame for one request and queues its bytes
  function automatic void append_frame(input cmd_req_t r, input logic [63:0] uid,
                                       input logic typed, input logic [7:0] t_chk,
                                       input logic [REPLY_W-1:0] t_rep);
    logic [7:0]         fb [0:23];
    logic [7:0]         code;
    logic [7:0]         len_lo;
    logic [7:0]         acc;
    logic [REPLY_W-1:0] rep;
    int unsigned        n;
    int unsigned        i;
    int unsigned        rep_full;
    bit                 wr;
    bit                 single;
    frame_byte_t        e;
    wr = (r.kind == KIND_WRITE) || (r.kind == KIND_FAST_WRITE);
    single = (r.kind == KIND_READ_SINGLE) || (r.kind == KIND_FAST_READ_SINGLE);
    case (r.kind)
      KIND_READ_SINGLE:      code = 8'h30;
      KIND_READ_MULTI:       code = 8'h33;
      KIND_FAST_READ_SINGLE: code = 8'hD0;
      KIND_FAST_READ_MULTI:  code = 8'hD3;
      KIND_READ_MULTI_UNLIM: code = 8'hB5;
      KIND_FAST_MULTI_UNLIM: code = 8'hD5;
      KIND_WRITE:            code = 8'h31;
      default:               code = 8'hD1;
    endcase
    if (wr) begin
      len_lo = LEN_WRITE;
      rep_full = 32'(WRITE_REPLY);
    end else if (single) begin
      len_lo = LEN_SINGLE;
      rep_full = BLOCK_BYTES_DEF + REPLY_BASE;
    end else begin
      len_lo = LEN_MULTI;
      rep_full = int'(r.block_count) * BLOCK_BYTES_DEF + REPLY_BASE;
    end
    if (rep_full > 32'(REPLY_MAX)) rep_full = 32'(REPLY_MAX);
    rep = rep_full[REPLY_W-1:0];
    fb[0] = HDR_BYTE;
    fb[1] = len_lo;
    fb[2] = LEN_HIGH;
    fb[3] = code;
    fb[4] = TAG_MARK;
    for (i = 0; i < 8; i++) fb[5 + i] = uid[8 * i +: 8];
    if (wr) begin
      for (i = 0; i < 8; i++) fb[13 + i] = r.wdata_lo[8 * i +: 8];
      fb[21] = r.wdata_hi;
      n = 22;
    end else begin
      fb[13] = r.first_block;
      n = 14;
      if (!single) begin
        // count zero wraps to 0xff here
        fb[14] = r.block_count - 8'd1;
        n = 15;
      end
    end
    // check byte covers everything after the header
    acc = 8'h00;
    for (i = 1; i < n; i++) acc = acc ^ fb[i];
    fb[n] = acc;
    n = n + 1;
    for (i = 0; i < n; i++) begin
      e.data = fb[i];
      e.last = (i == n - 1);
      e.reply = typed ? t_rep : rep;
      if (typed && e.last) e.data = t_chk;
      pending_bytes.push_back(e);
    end
  endfunction

  function automatic dir_row_t row(input kind_t k, input logic [7:0] start,
                                   input logic [7:0] count, input logic [63:0] lo,
                                   input logic [7:0] hi, input logic typed,
                                   input logic [7:0] chk, input logic [REPLY_W-1:0] rep);
    dir_row_t d;
    d.req.kind = k;
    d.req.first_block = start;
    d.req.block_count = count;
    d.req.wdata_lo = lo;
    d.req.wdata_hi = hi;
    d.typed = typed;
    d.chk = chk;
    d.reply = rep;
    return d;
  endfunction

  // offers one request and returns at the edge that takes it
  task automatic send_cmd(input cmd_req_t r, input logic typed, input logic [7:0] chk,
                          input logic [REPLY_W-1:0] rep);
    req_ch.valid           <= 1'b1;
    req_ch.kind            <= r.kind;
    req_ch.first_block     <= r.first_block;
    req_ch.block_count     <= r.block_count;
    req_ch.write_data_low  <= r.wdata_lo;
    req_ch.write_data_high <= r.wdata_hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    append_frame(r, uid_now, typed, chk, rep);
  endtask

  task automatic idle_gap();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 5);
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_uid(input logic [63:0] v);
    logic [63:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_TAG_UID;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    uid_now = v;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== v) begin
      $error("tag_uid readback expected %h got %h", v, got);
      errors++;
    end
  endtask

  task automatic run_phase(input int n_items, input press_t press);
    cmd_req_t r;
    int       k;
    for (k = 0; k < n_items; k++) begin
      r.kind = kind_t'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       r.block_count = 8'h00;
        1:       r.block_count = 8'h01;
        2:       r.block_count = 8'hFF;
        default: r.block_count = 8'($urandom_range(0, 255));
      endcase
      r.first_block = 8'($urandom_range(0, 255));
      r.wdata_lo = {$urandom, $urandom};
      r.wdata_hi = 8'($urandom_range(0, 255));
      send_cmd(r, 1'b0, 8'h00, '0);
      if (press == PRESS_HOLD && k == 5) hold_rx = 1'b1;
      if (press == PRESS_DRAIN && k == 10) begin
        // sender waits until every queued byte has come out
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
      end else begin
        idle_gap();
      end
    end
  endtask

  // receiver: stall patterns, plus one long hold on request
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned k;
    byte_ch.ready <= 1'b0;
    forever begin
      if (hold_rx) begin
        byte_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(8, 60);
      for (k = 0; k < span && !hold_rx; k++) begin
        case (mode)
          RX_OPEN:   byte_ch.ready <= 1'b1;
          RX_RANDOM: byte_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   byte_ch.ready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : byte_check
    frame_byte_t want;
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected frame byte %h", byte_ch.frame_byte);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (byte_ch.frame_byte !== want.data) begin
          $error("frame_byte expected %h got %h", want.data, byte_ch.frame_byte);
          errors++;
        end
        if (byte_ch.last_byte !== want.last) begin
          $error("last_byte expected %b got %b", want.last, byte_ch.last_byte);
          errors++;
        end
        if (byte_ch.reply_length !== want.reply) begin
          $error("reply_length expected %0d got %0d", want.reply, byte_ch.reply_length);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tab [$];
    int       i;
    errors = 0;
    hold_rx = 1'b0;
    burst_left = 0;
    uid_now = 64'h0;
    rst_n                  <= 1'b0;
    cfg_psel               <= 1'b0;
    cfg_penable            <= 1'b0;
    cfg_pwrite             <= 1'b0;
    cfg_paddr              <= ADDR_TAG_UID;
    cfg_pwdata             <= 64'h0;
    req_ch.valid           <= 1'b0;
    req_ch.kind            <= KIND_READ_SINGLE;
    req_ch.first_block     <= 8'h00;
    req_ch.block_count     <= 8'h01;
    req_ch.write_data_low  <= 64'h0;
    req_ch.write_data_high <= 8'h00;

    // tag uid is still at its reset value of zero for the whole table
    dir_tab.push_back(row(KIND_READ_SINGLE, 8'h00, 8'h01, 64'h0, 8'h00, 1'b1, 8'h19, 11'd13));
    dir_tab.push_back(row(KIND_READ_MULTI, 8'hFF, 8'hFF, 64'h0, 8'h00, 1'b1, 8'h1C, 11'd2045));
    // count zero: count byte wraps, reply is just the base
    dir_tab.push_back(row(KIND_FAST_READ_MULTI, 8'h00, 8'h00, 64'h0, 8'h00,
                          1'b1, 8'h02, 11'd5));
    dir_tab.push_back(row(KIND_WRITE, 8'h00, 8'h01, {64{1'b1}}, 8'hFF, 1'b1, 8'hFF, 11'd5));
    dir_tab.push_back(row(KIND_FAST_WRITE, 8'h00, 8'h01, 64'h0, 8'h00, 1'b1, 8'hE0, 11'd5));
    // unused operands set to junk
    dir_tab.push_back(row(KIND_FAST_READ_SINGLE, 8'hFF, 8'h00, {64{1'b1}}, 8'hFF,
                          1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_READ_MULTI_UNLIM, 8'h00, 8'h01, 64'h0, 8'h00, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_FAST_MULTI_UNLIM, 8'h5A, 8'h80, 64'h0, 8'h00, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_READ_MULTI, 8'h01, 8'h00, 64'h0, 8'h00, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_READ_MULTI_UNLIM, 8'h80, 8'hFF, 64'h0, 8'h00, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_FAST_MULTI_UNLIM, 8'hFF, 8'h02, {64{1'b1}}, 8'hFF,
                          1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_WRITE, 8'hFF, 8'hFF, 64'h0123_4567_89AB_CDEF, 8'h5A,
                          1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_FAST_WRITE, 8'hA5, 8'h00, 64'hAAAA_AAAA_5555_5555, 8'h80,
                          1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_READ_SINGLE, 8'hFF, 8'hFF, {64{1'b1}}, 8'hFF, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_FAST_READ_SINGLE, 8'h7F, 8'h01, 64'h0, 8'h00, 1'b0, 8'h00, '0));
    dir_tab.push_back(row(KIND_READ_MULTI, 8'h7E, 8'h01, 64'h0, 8'h00, 1'b0, 8'h00, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_tab.size(); i++) begin
      send_cmd(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].chk, dir_tab[i].reply);
      idle_gap();
    end

    settle();
    set_uid({64{1'b1}});
    run_phase(26, PRESS_NONE);
    settle();
    set_uid(64'hA55A_0FF0_3CC3_9669);
    run_phase(26, PRESS_HOLD);
    settle();
    set_uid({$urandom, $urandom});
    run_phase(26, PRESS_DRAIN);
    settle();
    set_uid(64'h0);
    run_phase(26, PRESS_NONE);
    settle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
